// ----- rtl/core/qfa_pkg.sv -----
// Shared types and widths for the quad face area datapath.
`timescale 1ns / 1ps
`default_nettype none
package qfa_pkg;

   localparam int COORD_W    = 24;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int LEN_RAD_W  = 2 * DIFF_W;
   localparam int LEN_W      = LEN_RAD_W / 2;
   localparam int PERIM_W    = LEN_W + 2;
   localparam int FAC_W      = LEN_W + 1;
   localparam int PX_W       = PERIM_W + FAC_W;
   localparam int PY_W       = 2 * FAC_W;
   localparam int SPLIT_W    = 26;
   localparam int HRN_RAD_W  = PX_W + PY_W + 1;
   localparam int HRN_ROOT_W = HRN_RAD_W / 2;
   localparam int AREA_W     = 40;
   localparam int SUM_W      = HRN_ROOT_W + 3;
   localparam int AREA_SHIFT = 15;

   typedef struct packed {
      logic signed [COORD_W-1:0] v0_x;
      logic signed [COORD_W-1:0] v0_y;
      logic signed [COORD_W-1:0] v0_z;
      logic signed [COORD_W-1:0] v1_x;
      logic signed [COORD_W-1:0] v1_y;
      logic signed [COORD_W-1:0] v1_z;
      logic signed [COORD_W-1:0] v2_x;
      logic signed [COORD_W-1:0] v2_y;
      logic signed [COORD_W-1:0] v2_z;
      logic signed [COORD_W-1:0] v3_x;
      logic signed [COORD_W-1:0] v3_y;
      logic signed [COORD_W-1:0] v3_z;
   } req_type;

   typedef struct packed {
      logic [AREA_W-1:0] face_area;
      logic              radicand_clamped;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/core/quad_face_area_heron.sv -----
// Quad face area from four corners: six rounded lengths, four Heron triangles.
// Throughput: one face per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the 25-stage length root and the 53-stage Heron root pipelines.
// Reset (synchronous) clears only the stage valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module quad_face_area_heron (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qfa_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output qfa_pkg::rsp_type rsp_payload
);

   import qfa_pkg::*;

   localparam int LEN_LAT   = LEN_RAD_W / 2;
   localparam int HRN_LAT   = HRN_RAD_W / 2;
   localparam int SUM_IDX   = 3;
   localparam int ROUND_IDX = SUM_IDX + LEN_LAT + 1;
   localparam int PREP_IDX  = ROUND_IDX + 1;
   localparam int RAD_IDX   = PREP_IDX + 4;
   localparam int ADD_IDX   = RAD_IDX + HRN_LAT + 1;
   localparam int OUT_IDX   = ADD_IDX + 1;
   localparam int PIPE_LAT  = OUT_IDX + 1;
   localparam int CLAMP_N   = ADD_IDX - PREP_IDX + 1;
   localparam int XH_W      = PX_W - SPLIT_W;
   localparam int YH_W      = PY_W - SPLIT_W;
   localparam int MID_W     = XH_W + SPLIT_W + 1;
   localparam int FULL_W    = SUM_W - AREA_SHIFT;
   localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (AREA_SHIFT - 1);

   // segments: e0 e1 e2 e3 d0 d1
   localparam int SEG_P [6] = '{0, 1, 2, 3, 1, 0};
   localparam int SEG_Q [6] = '{1, 2, 3, 0, 3, 2};
   // triangles (side a, side b, diagonal)
   localparam int TRI_A [4] = '{0, 1, 0, 2};
   localparam int TRI_B [4] = '{3, 2, 1, 3};
   localparam int TRI_C [4] = '{4, 4, 5, 5};

   logic                accept;
   logic [PIPE_LAT-1:0] vld_ff;
   logic [PIPE_LAT-1:0] vld_in;
   logic [CLAMP_N-1:0]  clamp_ff;
   logic [CLAMP_N-1:0]  clamp_in;
   req_type             in_ff;
   rsp_type             out_ff;
   rsp_type             out_in;

   logic signed [COORD_W-1:0] crd [4][3];
   logic [DIFF_W-1:0]     mag_ff [6][3];
   logic [LEN_RAD_W-1:0]  sq_ff  [6][3];
   logic [LEN_RAD_W-1:0]  lrad_ff [6];
   logic [LEN_W-1:0]      len_root [6];
   logic [LEN_W:0]        len_rem  [6];
   logic [LEN_W-1:0]      len_ff [6];

   logic [PERIM_W-1:0]    per_ff  [4];
   logic [FAC_W-1:0]      fac_ff  [4][3];
   logic                  kill_ff [4];
   logic [3:0]            tri_clamp;
   logic [PX_W-1:0]       x_ff [4];
   logic [PY_W-1:0]       y_ff [4];
   logic [XH_W+YH_W-1:0]  hh_ff [4];
   logic [XH_W+SPLIT_W-1:0] hl_ff [4];
   logic [SPLIT_W+YH_W-1:0] lh_ff [4];
   logic [2*SPLIT_W-1:0]  ll_ff [4];
   logic [XH_W+YH_W-1:0]  hh2_ff [4];
   logic [2*SPLIT_W-1:0]  ll2_ff [4];
   logic [MID_W-1:0]      mid_ff [4];
   logic [HRN_RAD_W-1:0]  hrad_ff [4];
   logic [HRN_ROOT_W-1:0] hrn_root [4];
   logic [HRN_ROOT_W:0]   hrn_rem0;
   logic [HRN_ROOT_W:0]   s01_ff;
   logic [HRN_ROOT_W:0]   s23_ff;
   logic [SUM_W-1:0]      area_sum;
   logic [SUM_W-1:0]      area_bias;
   logic [FULL_W-1:0]     area_full;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign vld_in   = {vld_ff[PIPE_LAT-2:0], accept};
   assign clamp_in = {clamp_ff[CLAMP_N-2:0], |tri_clamp};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff    <= req_payload;
      clamp_ff <= clamp_in;
      out_ff   <= out_in;
   end

   assign crd[0][0] = in_ff.v0_x;
   assign crd[0][1] = in_ff.v0_y;
   assign crd[0][2] = in_ff.v0_z;
   assign crd[1][0] = in_ff.v1_x;
   assign crd[1][1] = in_ff.v1_y;
   assign crd[1][2] = in_ff.v1_z;
   assign crd[2][0] = in_ff.v2_x;
   assign crd[2][1] = in_ff.v2_y;
   assign crd[2][2] = in_ff.v2_z;
   assign crd[3][0] = in_ff.v3_x;
   assign crd[3][1] = in_ff.v3_y;
   assign crd[3][2] = in_ff.v3_z;

   genvar s, k, t;
   generate
      for (s = 0; s < 6; s++) begin : g_seg
         logic [LEN_W-1:0] len_in;

         for (k = 0; k < 3; k++) begin : g_axis
            logic [DIFF_W-1:0] diff;
            logic [DIFF_W-1:0] ndiff;
            logic [DIFF_W-1:0] mag_in;
            logic [LEN_RAD_W-1:0] sq_in;

            assign diff   = {crd[SEG_P[s]][k][COORD_W-1], crd[SEG_P[s]][k]}
                          - {crd[SEG_Q[s]][k][COORD_W-1], crd[SEG_Q[s]][k]};
            assign ndiff  = DIFF_W'(0) - diff;
            assign mag_in = diff[DIFF_W-1] ? ndiff : diff;
            assign sq_in  = LEN_RAD_W'(mag_ff[s][k]) * LEN_RAD_W'(mag_ff[s][k]);

            always_ff @(posedge clock) begin
               mag_ff[s][k] <= mag_in;
               sq_ff[s][k]  <= sq_in;
            end
         end

         always_ff @(posedge clock) begin
            lrad_ff[s] <= sq_ff[s][0] + sq_ff[s][1] + sq_ff[s][2];
            len_ff[s]  <= len_in;
         end

         qfa_sqrt #(
            .RAD_W (LEN_RAD_W)
         ) u_len_sqrt (
            .clock  (clock),
            .rad_i  (lrad_ff[s]),
            .root_o (len_root[s]),
            .rem_o  (len_rem[s])
         );

         // round to nearest: bump when remainder exceeds root
         assign len_in = len_root[s] + LEN_W'(len_rem[s] > {1'b0, len_root[s]});
      end

      for (t = 0; t < 4; t++) begin : g_tri
         logic [PERIM_W-1:0] sa;
         logic [PERIM_W-1:0] sb;
         logic [PERIM_W-1:0] sc;
         logic [PERIM_W-1:0] per_in;
         logic [PERIM_W-1:0] q [3];
         logic [PERIM_W-1:0] nq [3];
         logic [FAC_W-1:0]   fac_in [3];
         logic               zero;
         logic               odd;
         logic [PX_W-1:0]    x_in;
         logic [PY_W-1:0]    y_in;

         assign sa     = PERIM_W'(len_ff[TRI_A[t]]);
         assign sb     = PERIM_W'(len_ff[TRI_B[t]]);
         assign sc     = PERIM_W'(len_ff[TRI_C[t]]);
         assign per_in = sa + sb + sc;
         assign q[0]   = sb + sc - sa;
         assign q[1]   = sa + sc - sb;
         assign q[2]   = sa + sb - sc;

         for (k = 0; k < 3; k++) begin : g_fac
            assign nq[k]     = PERIM_W'(0) - q[k];
            assign fac_in[k] = q[k][PERIM_W-1] ? nq[k][FAC_W-1:0] : q[k][FAC_W-1:0];
         end

         assign zero = (per_in == '0) || (q[0] == '0) || (q[1] == '0) || (q[2] == '0);
         assign odd  = q[0][PERIM_W-1] ^ q[1][PERIM_W-1] ^ q[2][PERIM_W-1];
         assign tri_clamp[t] = ~zero & odd;

         // a killed triangle feeds zero into the multiplier
         assign x_in = kill_ff[t] ? '0 : PX_W'(per_ff[t]) * PX_W'(fac_ff[t][0]);
         assign y_in = kill_ff[t] ? '0 : PY_W'(fac_ff[t][1]) * PY_W'(fac_ff[t][2]);

         always_ff @(posedge clock) begin
            per_ff[t]    <= per_in;
            fac_ff[t][0] <= fac_in[0];
            fac_ff[t][1] <= fac_in[1];
            fac_ff[t][2] <= fac_in[2];
            kill_ff[t]   <= zero | odd;
            x_ff[t]      <= x_in;
            y_ff[t]      <= y_in;
            hh_ff[t]     <= (XH_W+YH_W)'(x_ff[t][PX_W-1:SPLIT_W])
                          * (XH_W+YH_W)'(y_ff[t][PY_W-1:SPLIT_W]);
            hl_ff[t]     <= (XH_W+SPLIT_W)'(x_ff[t][PX_W-1:SPLIT_W])
                          * (XH_W+SPLIT_W)'(y_ff[t][SPLIT_W-1:0]);
            lh_ff[t]     <= (SPLIT_W+YH_W)'(x_ff[t][SPLIT_W-1:0])
                          * (SPLIT_W+YH_W)'(y_ff[t][PY_W-1:SPLIT_W]);
            ll_ff[t]     <= (2*SPLIT_W)'(x_ff[t][SPLIT_W-1:0])
                          * (2*SPLIT_W)'(y_ff[t][SPLIT_W-1:0]);
            mid_ff[t]    <= MID_W'(hl_ff[t]) + MID_W'(lh_ff[t]);
            hh2_ff[t]    <= hh_ff[t];
            ll2_ff[t]    <= ll_ff[t];
            hrad_ff[t]   <= HRN_RAD_W'({hh2_ff[t], ll2_ff[t]})
                          + (HRN_RAD_W'(mid_ff[t]) << SPLIT_W);
         end

         if (t == 0) begin : g_rem
            qfa_sqrt #(
               .RAD_W (HRN_RAD_W)
            ) u_hrn_sqrt (
               .clock  (clock),
               .rad_i  (hrad_ff[t]),
               .root_o (hrn_root[t]),
               .rem_o  (hrn_rem0)
            );
         end else begin : g_norem
            qfa_sqrt #(
               .RAD_W (HRN_RAD_W)
            ) u_hrn_sqrt (
               .clock  (clock),
               .rad_i  (hrad_ff[t]),
               .root_o (hrn_root[t]),
               .rem_o  ()
            );
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      s01_ff <= (HRN_ROOT_W+1)'(hrn_root[0]) + (HRN_ROOT_W+1)'(hrn_root[1]);
      s23_ff <= (HRN_ROOT_W+1)'(hrn_root[2]) + (HRN_ROOT_W+1)'(hrn_root[3]);
   end

   assign area_sum  = SUM_W'(s01_ff) + SUM_W'(s23_ff);
   assign area_bias = area_sum + ROUND_BIAS;
   assign area_full = area_bias[SUM_W-1:AREA_SHIFT];

   always_comb begin
      out_in.radicand_clamped = clamp_ff[CLAMP_N-1];
      if (|area_full[FULL_W-1:AREA_W]) begin
         out_in.face_area = '1;
      end else begin
         out_in.face_area = area_full[AREA_W-1:0];
      end
   end

   assign rsp_strobe  = vld_ff[OUT_IDX];
   assign rsp_payload = out_ff;

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LAT rsp_strobe)
      else $error("transfer did not produce a result at the expected cycle");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, PIPE_LAT))
      else $error("result without a matching transfer");

   a_len_rem : assert property (@(posedge clock) disable iff (reset)
      vld_ff[ROUND_IDX-1] |-> (len_rem[0] <= {len_root[0], 1'b0}))
      else $error("length root remainder out of range");

   a_hrn_rem : assert property (@(posedge clock) disable iff (reset)
      vld_ff[ADD_IDX-1] |-> (hrn_rem0 <= {hrn_root[0], 1'b0}))
      else $error("triangle root remainder out of range");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/qfa_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with remainder.
`timescale 1ns / 1ps
`default_nettype none
module qfa_sqrt #(
   parameter int RAD_W = qfa_pkg::LEN_RAD_W
) (
   input  logic               clock,
   input  logic [RAD_W-1:0]   rad_i,
   output logic [RAD_W/2-1:0] root_o,
   output logic [RAD_W/2:0]   rem_o
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];

   genvar k;
   generate
      for (k = 0; k < ROOT_W; k++) begin : g_step
         logic [REM_W-1:0]  rem_pv;
         logic [REM_W-1:0]  rem_sh;
         logic [REM_W-1:0]  trial;
         logic [REM_W-1:0]  rem_in;
         logic [ROOT_W-1:0] root_pv;
         logic [ROOT_W-1:0] root_in;
         logic [RAD_W-1:0]  rad_pv;
         logic [RAD_W-1:0]  rad_in;
         logic              ge;

         if (k == 0) begin : g_first
            assign rem_pv  = '0;
            assign root_pv = '0;
            assign rad_pv  = rad_i;
         end else begin : g_next
            assign rem_pv  = rem_ff[k-1];
            assign root_pv = root_ff[k-1];
            assign rad_pv  = rad_ff[k-1];
         end

         assign rem_sh  = {rem_pv[ROOT_W-1:0], rad_pv[RAD_W-1 -: 2]};
         assign trial   = {root_pv, 2'b01};
         assign ge      = (rem_sh >= trial);
         assign rem_in  = ge ? (rem_sh - trial) : rem_sh;
         assign root_in = {root_pv[ROOT_W-2:0], ge};
         assign rad_in  = {rad_pv[RAD_W-3:0], 2'b00};

         always_ff @(posedge clock) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_in;
         end
      end
   endgenerate

   assign root_o = root_ff[ROOT_W-1];
   assign rem_o  = rem_ff[ROOT_W-1][ROOT_W:0];

endmodule
`default_nettype wire
